// ===== rtl/image_conv3x3_zero_pad_macros.svh =====
// Assertion macros shared by the 3x3 convolution RTL.
`ifndef IMAGE_CONV3X3_ZERO_PAD_MACROS_SVH
`define IMAGE_CONV3X3_ZERO_PAD_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define ICZ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icz: assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ICZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icz: assertion failed");
`else
`define ICZ_ASSERT_IMP(label, clk, rst, ante, cons)
`define ICZ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/icz_pkg.sv =====
// Shared constants, types and helpers for the 3x3 zero-padded convolution.
package icz_pkg;

   // Frame size limits.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

   // Dimension values and the input row counter, which runs up to height + 1.
   localparam int DIM_W = $clog2(MAX_DIM + 2);
   // Column index into the line buffers, and the output row index.
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // Field widths.
   localparam int PIX_W     = 8;
   localparam int SUM_W     = 13;
   localparam int MODE_W    = 2;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int WIN_N     = 9;

   // Queue between the front and back halves.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QLVL_W = $clog2(QDEPTH + 1);

   // Divide by nine as multiply by a reciprocal; exact for sums up to 9 * 255.
   localparam int TOT_W       = 12;
   localparam int DIV9_RECIP  = 7282;
   localparam int RECIP_W     = 13;
   localparam int DIV9_SHIFT  = 16;
   localparam int PROD_W      = TOT_W + RECIP_W;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   // Request opcodes.
   localparam logic OP_DRAIN = 1'b1;

   // Kernel modes; any other code selects the box average.
   localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LAPLACE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Reset values of the registers.
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
   localparam logic [CSR_W-1:0]  DIM_RESET  = 11'd256;

   typedef logic [WIN_N-1:0][PIX_W-1:0] window_type;

   // Settings seen by the front and back halves.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic              restart;
   } cfg_type;

   // Zero acts as one, and values above the bound saturate to it.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CSR_W-1:0] v, input int bound);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > bound) begin
         r = DIM_W'(bound);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== rtl/icz_front.sv =====
// Front half: accepts requests, keeps the line buffers and builds the 3x3 window.
`include "image_conv3x3_zero_pad_macros.svh"
module icz_front (
   input  logic                       clock,
   input  logic                       reset,
   input  icz_pkg::cfg_type           cfg,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [icz_pkg::PIX_W-1:0]  req_pixel_in,
   input  logic [icz_pkg::QLVL_W-1:0] q_level,
   output logic                       q_push,
   output icz_pkg::window_type        q_push_win
);
   import icz_pkg::*;

   logic [DIM_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;

   logic             s1_valid_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;

   logic [PIX_W-1:0] line_above_mem     [MAX_WIDTH];
   logic [PIX_W-1:0] line_two_above_mem [MAX_WIDTH];
   logic [PIX_W-1:0] mid_rd_ff;
   logic [PIX_W-1:0] top_rd_ff;

   window_type window_ff, window_in, shifted;

   logic             accept;
   logic             pixel_phase;
   logic             active;
   logic             emit;
   logic             last;
   logic             col_wrap;
   logic [PIX_W-1:0] pix_eff;
   logic [QLVL_W:0]  pending;

   // Hold off requests while the queue plus the item about to enter it is full.
   assign pending   = {1'b0, q_level} + (QLVL_W+1)'(s1_valid_ff && s1_emit_ff);
   assign req_stall = pending >= (QLVL_W+1)'(QDEPTH);
   assign accept    = req_valid && !req_stall;

   // Classify the request: a drain before the frame is complete does nothing,
   // and a push after the frame is complete only flushes.
   assign pixel_phase = in_row_ff < cfg.height;
   assign active      = accept && !(pixel_phase && req_opcode == OP_DRAIN);
   assign pix_eff     = pixel_phase ? req_pixel_in : '0;

   // A result is due once the window has passed one row and one pixel.
   assign emit = (in_row_ff >= DIM_W'(2)) || (in_row_ff == DIM_W'(1) && in_col_ff != '0);
   // The last result of the frame is due one row and one pixel after its end.
   assign last     = (in_row_ff == cfg.height + DIM_W'(1)) && (in_col_ff == '0);
   assign col_wrap = (DIM_W'(in_col_ff) + DIM_W'(1)) >= cfg.width;

   // Input position counters.
   always_comb begin
      in_row_in = in_row_ff;
      in_col_in = in_col_ff;
      if (cfg.restart) begin
         in_row_in = '0;
         in_col_in = '0;
      end else if (active) begin
         if (last) begin
            in_row_in = '0;
            in_col_in = '0;
         end else if (col_wrap) begin
            in_row_in = in_row_ff + DIM_W'(1);
            in_col_in = '0;
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
      end
   end

   // Row above: read the old byte and store the new pixel in the same cycle.
   always_ff @(posedge clock) begin
      if (active) begin
         mid_rd_ff                 <= line_above_mem[in_col_ff];
         line_above_mem[in_col_ff] <= pix_eff;
      end
   end

   // Row two above takes the byte read from the row above in the following cycle.
   // With a one-pixel row the next request reads that same entry, so the
   // pending byte is forwarded.
   always_ff @(posedge clock) begin
      if (active) begin
         if (s1_valid_ff && s1_col_ff == in_col_ff) begin
            top_rd_ff <= mid_rd_ff;
         end else begin
            top_rd_ff <= line_two_above_mem[in_col_ff];
         end
      end
      if (s1_valid_ff) begin
         line_two_above_mem[s1_col_ff] <= mid_rd_ff;
      end
   end

   // Stage one carries the request while the line buffers are read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= active;
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         s1_pix_ff  <= pix_eff;
         s1_col_ff  <= in_col_ff;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
      end
   end

   // Shift a new column of above, center and below into the window.
   always_comb begin
      shifted         = window_ff;
      shifted[5:0]    = window_ff[8:3];
      shifted[6]      = top_rd_ff;
      shifted[7]      = mid_rd_ff;
      shifted[8]      = s1_pix_ff;
   end

   always_comb begin
      window_in = window_ff;
      if (cfg.restart) begin
         window_in = '0;
      end else if (s1_valid_ff) begin
         window_in = s1_last_ff ? '0 : shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign q_push     = s1_valid_ff && s1_emit_ff;
   assign q_push_win = shifted;

   `ICZ_ASSERT_IMP(a_col_in_frame, clock, reset, !cfg.restart, DIM_W'(in_col_ff) < cfg.width)
   `ICZ_ASSERT_NEXT(a_window_cleared, clock, reset, s1_valid_ff && s1_last_ff, window_ff == '0)

endmodule

// ===== rtl/icz_queue.sv =====
// Short queue of windows between the front and back halves.
`include "image_conv3x3_zero_pad_macros.svh"
module icz_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  icz_pkg::window_type        push_win,
   input  logic                       pop,
   output icz_pkg::window_type        head_win,
   output logic                       empty,
   output logic [icz_pkg::QLVL_W-1:0] level
);
   import icz_pkg::*;

   window_type        entries_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + QLVL_W'(push) - QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_win;
      end
   end

   assign head_win = entries_ff[rd_ptr_ff];
   assign empty    = (level_ff == '0);
   assign level    = level_ff;

   `ICZ_ASSERT_IMP(a_no_push_when_full, clock, reset, push, level_ff != QLVL_W'(QDEPTH))
   `ICZ_ASSERT_IMP(a_no_pop_when_empty, clock, reset, pop, level_ff != '0)

endmodule

// ===== rtl/icz_back.sv =====
// Back half: masks the window by position, applies the kernel and holds the result.
`include "image_conv3x3_zero_pad_macros.svh"
module icz_back (
   input  logic                              clock,
   input  logic                              reset,
   input  icz_pkg::cfg_type                  cfg,
   input  logic                              q_empty,
   input  icz_pkg::window_type               q_head_win,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [icz_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic signed [icz_pkg::SUM_W-1:0]  rsp_raw_sum,
   output logic                              rsp_frame_last
);
   import icz_pkg::*;

   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;

   logic                    b1_valid_ff;
   logic                    b1_box_ff;
   logic                    b1_last_ff;
   logic signed [SUM_W-1:0] b1_val_ff;

   logic                    rsp_valid_ff;
   logic [PIX_W-1:0]        rsp_pixel_out_ff;
   logic signed [SUM_W-1:0] rsp_raw_sum_ff;
   logic                    rsp_frame_last_ff;

   logic out_free;
   logic b1_free;
   logic up_ok, dn_ok, lf_ok, rt_ok;
   logic at_last;
   logic col_wrap;

   logic signed [SUM_W-1:0] ce_s, up_s, dn_s, lf_s, rt_s;
   logic signed [SUM_W-1:0] ul_s, ur_s, dl_s, dr_s;
   logic signed [SUM_W-1:0] val;
   logic                    is_box;

   logic [PROD_W-1:0]            prod;
   logic [PROD_W-DIV9_SHIFT-1:0] quot;
   logic signed [SUM_W-1:0]      res;
   logic [PIX_W-1:0]             clip;

   // Elastic handshake through stage one and the output register.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign b1_free  = !b1_valid_ff || out_free;
   assign q_pop    = !q_empty && b1_free;

   // Which neighbors lie inside the frame.
   assign up_ok    = out_row_ff != '0;
   assign dn_ok    = (DIM_W'(out_row_ff) + DIM_W'(1)) < cfg.height;
   assign lf_ok    = out_col_ff != '0;
   assign rt_ok    = (DIM_W'(out_col_ff) + DIM_W'(1)) < cfg.width;
   assign col_wrap = !rt_ok;
   assign at_last  = (DIM_W'(out_row_ff) == cfg.height - DIM_W'(1)) && col_wrap;

   // Output position counters.
   always_comb begin
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (cfg.restart) begin
         out_row_in = '0;
         out_col_in = '0;
      end else if (q_pop) begin
         if (at_last) begin
            out_row_in = '0;
            out_col_in = '0;
         end else if (col_wrap) begin
            out_row_in = out_row_ff + ROW_W'(1);
            out_col_in = '0;
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // Masked window terms; column one is the center column.
   always_comb begin
      ce_s = $signed(SUM_W'(q_head_win[4]));
      up_s = up_ok ? $signed(SUM_W'(q_head_win[3])) : '0;
      dn_s = dn_ok ? $signed(SUM_W'(q_head_win[5])) : '0;
      lf_s = lf_ok ? $signed(SUM_W'(q_head_win[1])) : '0;
      rt_s = rt_ok ? $signed(SUM_W'(q_head_win[7])) : '0;
      ul_s = (up_ok && lf_ok) ? $signed(SUM_W'(q_head_win[0])) : '0;
      ur_s = (up_ok && rt_ok) ? $signed(SUM_W'(q_head_win[6])) : '0;
      dl_s = (dn_ok && lf_ok) ? $signed(SUM_W'(q_head_win[2])) : '0;
      dr_s = (dn_ok && rt_ok) ? $signed(SUM_W'(q_head_win[8])) : '0;
   end

   // Kernel sum; the box average keeps the plain total for the divide stage.
   always_comb begin
      case (cfg.mode)
         MODE_SHARPEN: begin
            val    = (ce_s <<< 3) + ce_s - ((up_s <<< 1) + up_s) - lf_s
                     - ((rt_s <<< 1) + rt_s) - dn_s;
            is_box = 1'b0;
         end
         MODE_LAPLACE: begin
            val    = (ce_s <<< 2) - up_s - dn_s - lf_s - rt_s;
            is_box = 1'b0;
         end
         default: begin
            val    = ce_s + up_s + dn_s + lf_s + rt_s + ul_s + ur_s + dl_s + dr_s;
            is_box = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else if (b1_free) begin
         b1_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_val_ff  <= val;
         b1_box_ff  <= is_box;
         b1_last_ff <= at_last;
      end
   end

   // Floor of the total over nine for the box average, then clip to a byte.
   always_comb begin
      prod = PROD_W'(b1_val_ff[TOT_W-1:0]) * PROD_W'(DIV9_RECIP);
      quot = prod[PROD_W-1:DIV9_SHIFT];
      res  = b1_box_ff ? $signed(SUM_W'(quot)) : b1_val_ff;
      if (res < 0) begin
         clip = '0;
      end else if (res > $signed(SUM_W'(PIX_MAX))) begin
         clip = PIX_MAX;
      end else begin
         clip = res[PIX_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_valid_ff && out_free) begin
         rsp_pixel_out_ff  <= clip;
         rsp_raw_sum_ff    <= res;
         rsp_frame_last_ff <= b1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_out_ff;
   assign rsp_raw_sum    = rsp_raw_sum_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   `ICZ_ASSERT_IMP(a_row_in_frame, clock, reset, !cfg.restart, DIM_W'(out_row_ff) < cfg.height)
   `ICZ_ASSERT_IMP(a_clip_matches_sum, clock, reset, rsp_valid_ff && rsp_raw_sum_ff >= 0 && rsp_raw_sum_ff <= 255, rsp_pixel_out_ff == rsp_raw_sum_ff[PIX_W-1:0])

endmodule

// ===== rtl/image_conv3x3_zero_pad.sv =====
// Top level of the streaming 3x3 zero-padded convolution.
//
// Pixels of one frame arrive in raster order on the req channel, one request per clock at
// full rate while req_stall is low; each pixel is filtered by the box average, sharpen or
// Laplacian kernel with neighbors outside the frame counted as zero. The result for a pixel
// is produced once image_width + 1 further requests (pushes or drain ticks) have been
// accepted, so a frame needs image_width + 1 drain ticks after its last pixel. Requests are
// taken one per clock while req_stall is low; the rate is set by the two line buffers, each
// of which does one read and one write per cycle. An accepted request passes through the
// line buffer read, window shift, queue, kernel sum, and divide and clip on its way to rsp.
// The line buffers need no clearing after reset, since bytes from outside the frame are
// masked by position. Write the registers only while the block is idle; a write of
// image_width or image_height starts a new frame.
module image_conv3x3_zero_pad (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [icz_pkg::PIX_W-1:0]           req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [icz_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic signed [icz_pkg::SUM_W-1:0]    rsp_raw_sum,
   output logic                                rsp_frame_last,
   input  logic                                csr_write_en,
   input  logic [icz_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [icz_pkg::CSR_W-1:0]           csr_wdata
);
   import icz_pkg::*;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;

   cfg_type    cfg;
   logic       restart;
   logic       q_push;
   logic       q_pop;
   logic       q_empty;
   window_type q_push_win;
   window_type q_head_win;
   logic [QLVL_W-1:0] q_level;

   // Register writes; dimensions are stored already clamped to their legal range.
   assign restart = csr_write_en &&
                    (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_KERNEL_MODE:  mode_in   = csr_wdata[MODE_W-1:0];
            CSR_IMAGE_WIDTH:  width_in  = eff_dim(csr_wdata, MAX_WIDTH);
            CSR_IMAGE_HEIGHT: height_in = eff_dim(csr_wdata, MAX_HEIGHT);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         width_ff  <= eff_dim(DIM_RESET, MAX_WIDTH);
         height_ff <= eff_dim(DIM_RESET, MAX_HEIGHT);
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      cfg.mode    = mode_ff;
      cfg.width   = width_ff;
      cfg.height  = height_ff;
      cfg.restart = restart;
   end

   icz_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_pixel_in (req_pixel_in),
      .q_level      (q_level),
      .q_push       (q_push),
      .q_push_win   (q_push_win)
   );

   icz_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_win (q_push_win),
      .pop      (q_pop),
      .head_win (q_head_win),
      .empty    (q_empty),
      .level    (q_level)
   );

   icz_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_empty        (q_empty),
      .q_head_win     (q_head_win),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_raw_sum    (rsp_raw_sum),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 zero-padded image convolution.
module tb;
   import icz_pkg::*;

   localparam logic                 OP_PUSH    = 1'b0;
   localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   localparam int ITEM_TARGET   = 1850;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;

   // One filtered pixel as it leaves the block.
   typedef struct packed {
      logic [PIX_W-1:0]        pix;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } conv_result_t;

   // One request waiting to be driven; settle holds it until all results are in.
   typedef struct {
      logic             op;
      logic [PIX_W-1:0] pixel;
      bit               settle;
   } pixel_req_t;

   logic                    clock;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_stall;
   logic                    req_opcode     = OP_PUSH;
   logic [PIX_W-1:0]        req_pixel_in   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall      = 1'b0;
   logic [PIX_W-1:0]        rsp_pixel_out;
   logic signed [SUM_W-1:0] rsp_raw_sum;
   logic                    rsp_frame_last;
   logic                    csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = CSR_KERNEL_MODE;
   logic [CSR_W-1:0]        csr_wdata      = '0;

   image_conv3x3_zero_pad dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_raw_sum    (rsp_raw_sum),
      .rsp_frame_last (rsp_frame_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Predictor state: two previous rows, the 3x3 window and the frame positions.
   logic [PIX_W-1:0]  row_prev  [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]  row_prev2 [MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]  nbhd [9] = '{default: '0};
   int unsigned       push_row = 0, push_col = 0, emit_row = 0, emit_col = 0;
   logic [MODE_W-1:0] mode_reg   = MODE_RESET;
   logic [CSR_W-1:0]  width_reg  = DIM_RESET;
   logic [CSR_W-1:0]  height_reg = DIM_RESET;

   pixel_req_t   pixel_requests[$];
   conv_result_t pending_results[$];

   int unsigned results_due = 0, quiet_cycles = 0;
   int unsigned burst_left = 0, gap_left = 0, stall_left = 0, stall_style = 0;
   int unsigned n_pixels = 0, n_ticks = 0, ignored_ticks = 0, n_results = 0, n_frames = 0;
   int unsigned csr_writes = 0, errors = 0, random_items = 0;
   bit          paused_once = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A dimension of zero acts as one and large values clamp to the buffer size.
   function automatic int unsigned clamp_dim(input logic [CSR_W-1:0] v, input int unsigned bound);
      if (v == '0) return 1;
      if (v > bound) return bound;
      return v;
   endfunction

   function automatic void frame_restart();
      push_row = 0;
      push_col = 0;
      emit_row = 0;
      emit_col = 0;
      nbhd = '{default: '0};
   endfunction

   // Advances the predictor by one accepted request; returns 1 when a result is due.
   function automatic bit filter_pixel(input logic op, input logic [PIX_W-1:0] pixel,
                                       output conv_result_t res);
      int unsigned w, h, col, pos, k;
      logic [PIX_W-1:0] px, top, mid;
      int ce, up, dn, lf, rt, acc, clip;
      bit up_ok, dn_ok, lf_ok, rt_ok;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      res = '0;
      // A drain tick before the frame's last pixel changes nothing.
      if (push_row < h && op == OP_DRAIN) begin
         ignored_ticks++;
         return 1'b0;
      end
      // Once the frame is fully pushed, every request flushes with a zero pixel.
      if (push_row < h) begin
         px = pixel;
         n_pixels++;
      end else begin
         px = '0;
         n_ticks++;
      end
      if (push_col >= w) push_col = 0;
      col = push_col;
      top = row_prev2[col];
      mid = row_prev[col];
      row_prev2[col] = mid;
      row_prev[col] = px;
      for (k = 0; k < 6; k++) nbhd[k] = nbhd[k + 3];
      nbhd[6] = top;
      nbhd[7] = mid;
      nbhd[8] = px;
      pos = push_row * w + push_col;
      push_col++;
      if (push_col >= w) begin
         push_col = 0;
         push_row++;
      end
      if (pos < w + 1) return 1'b0;

      // The middle window column is the output pixel; mask neighbors by position.
      up_ok = emit_row >= 1;
      dn_ok = emit_row + 1 < h;
      lf_ok = emit_col >= 1;
      rt_ok = emit_col + 1 < w;
      ce = nbhd[4];
      up = up_ok ? nbhd[3] : 0;
      dn = dn_ok ? nbhd[5] : 0;
      lf = lf_ok ? nbhd[1] : 0;
      rt = rt_ok ? nbhd[7] : 0;
      case (mode_reg)
         MODE_SHARPEN: acc = 9 * ce - 3 * up - lf - 3 * rt - dn;
         MODE_LAPLACE: acc = 4 * ce - up - dn - lf - rt;
         default: begin
            acc = ce + up + dn + lf + rt;
            if (up_ok && lf_ok) acc += nbhd[0];
            if (up_ok && rt_ok) acc += nbhd[6];
            if (dn_ok && lf_ok) acc += nbhd[2];
            if (dn_ok && rt_ok) acc += nbhd[8];
            acc = acc / 9;
         end
      endcase
      clip = (acc < 0) ? 0 : ((acc > 255) ? 255 : acc);
      res.pix = clip[PIX_W-1:0];
      res.sum = acc[SUM_W-1:0];
      res.last = (emit_row == h - 1) && (emit_col == w - 1);
      emit_col++;
      if (emit_col >= w) begin
         emit_col = 0;
         emit_row++;
      end
      if (res.last) frame_restart();
      return 1'b1;
   endfunction

   // Register write while the block is idle; the predictor follows at the same edge.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_KERNEL_MODE: mode_reg = val[MODE_W-1:0];
         CSR_IMAGE_WIDTH: begin
            width_reg = val;
            frame_restart();
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = val;
            frame_restart();
         end
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic queue_request(input logic op, input logic [PIX_W-1:0] pixel, input bit settle);
      pixel_req_t item;
      item.op = op;
      item.pixel = pixel;
      item.settle = settle;
      pixel_requests.push_back(item);
   endtask

   // Waits until every request is taken and every result checked, then lets the pipe empty.
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_requests.size() != 0 || req_valid || pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A 1x1 frame needs two flush ticks after its pixel.
   task automatic single_pixel(input logic [PIX_W-1:0] pixel);
      @(negedge clock);
      queue_request(OP_PUSH, pixel, 1'b0);
      queue_request(OP_DRAIN, 8'h5A, 1'b0);
      queue_request(OP_DRAIN, 8'hA5, 1'b0);
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return PIX_MAX;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return 2;
         9: return $urandom_range(11, 40);
         default: return $urandom_range(3, 10);
      endcase
   endfunction

   // Keeps frames small so that many of them fit in the run.
   function automatic logic [CSR_W-1:0] pick_height();
      int unsigned lim;
      lim = 240 / clamp_dim(width_reg, MAX_WIDTH);
      if (lim > 30) lim = 30;
      if ($urandom_range(0, 9) == 0) return '0;
      return $urandom_range(1, lim);
   endfunction

   // Queues well-formed frames with random content, plus stray drain ticks, pushes
   // during the flush and, when allowed, a frame cut short at a random point.
   task automatic play_frames(input int frames, input bit may_cut);
      int unsigned w, h, area, span, pos;
      int made, cap;
      bit hold;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      area = w * h;
      span = area + w + 1;
      made = 0;
      cap = (may_cut && $urandom_range(0, 2) == 0) ? int'($urandom_range(0, span)) : -1;
      // Resume wherever the previous phase left the frame.
      pos = push_row * w + push_col;
      repeat (frames) begin
         while (pos < span) begin
            if (cap >= 0 && made >= cap) return;
            hold = (!paused_once && made == 5) || ($urandom_range(0, 299) == 0);
            if (hold) paused_once = 1'b1;
            if (pos < area) begin
               if ($urandom_range(0, 19) == 0) queue_request(OP_DRAIN, pick_pixel(), 1'b0);
               queue_request(OP_PUSH, pick_pixel(), hold);
            end else begin
               queue_request(($urandom_range(0, 7) == 0) ? OP_PUSH : OP_DRAIN, pick_pixel(),
                             hold);
            end
            made++;
            random_items++;
            pos++;
         end
         pos = 0;
         // A drain tick at the start of the next frame is ignored.
         if ($urandom_range(0, 5) == 0) queue_request(OP_DRAIN, pick_pixel(), 1'b0);
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      pixel_req_t item;
      bit send;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         send = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pixel_requests.size() != 0 &&
                      !(pixel_requests[0].settle && (results_due != 0 || req_valid))) begin
            item = pixel_requests.pop_front();
            send = 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                        : $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                          $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 4);
            end
         end
         req_valid <= send;
         if (send) begin
            req_opcode <= item.op;
            req_pixel_in <= item.pixel;
         end
      end
   end

   // Result stall pattern: free-running, light random, periodic heavy, or coin flip.
   always @(posedge clock) begin
      bit hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 160);
         end
         stall_left--;
         case (stall_style)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 3) == 0);
            2: hold = (stall_left % 4) != 0;
            default: hold = $urandom_range(0, 1);
         endcase
         rsp_stall <= hold;
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted result.
   always @(posedge clock) begin
      conv_result_t got, want, due;
      bit moved;
      if (reset) begin
         results_due <= 0;
         quiet_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (filter_pixel(req_opcode, req_pixel_in, due)) pending_results.push_back(due);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            n_results++;
            got.pix = rsp_pixel_out;
            got.sum = rsp_raw_sum;
            got.last = rsp_frame_last;
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected result: pix=%0d sum=%0d last=%0b",
                           got.pix, got.sum, got.last);
            end else begin
               want = pending_results.pop_front();
               if (want.last) n_frames++;
               if (got.pix !== want.pix || got.sum !== want.sum || got.last !== want.last) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("result %0d: expected pix=%0d sum=%0d last=%0b, got pix=%0d sum=%0d last=%0b",
                              n_results, want.pix, want.sum, want.last,
                              got.pix, got.sum, got.last);
               end
            end
         end
         results_due <= pending_results.size();
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog on cycles in which neither channel moves.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_results.size());
      $display("tb: done, errors");
      $finish;
   end

   // Stimulus: directed frames first, then random phases, then the largest frames.
   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sharpen on a 3x3 frame of full-scale pixels around a black center; a write to
      // the unused register index must change nothing.
      csr_write(CSR_KERNEL_MODE, MODE_SHARPEN);
      csr_write(CSR_IMAGE_WIDTH, 3);
      csr_write(CSR_IMAGE_HEIGHT, 3);
      csr_write(CSR_SPARE, 5);
      @(negedge clock);
      queue_request(OP_DRAIN, PIX_MAX, 1'b0);
      for (k = 0; k < 9; k++) queue_request(OP_PUSH, (k == 4) ? 8'h00 : PIX_MAX, 1'b0);
      queue_request(OP_PUSH, 8'h55, 1'b0);
      repeat (3) queue_request(OP_DRAIN, 8'h00, 1'b0);
      wait_idle();

      // Unused mode acts as the box average; zero width acts as one.
      csr_write(CSR_KERNEL_MODE, MODE_SPARE);
      csr_write(CSR_IMAGE_WIDTH, 0);
      csr_write(CSR_IMAGE_HEIGHT, 1);
      single_pixel(PIX_MAX);
      wait_idle();
      csr_write(CSR_KERNEL_MODE, MODE_SHARPEN);
      single_pixel(PIX_MAX);
      wait_idle();
      csr_write(CSR_KERNEL_MODE, MODE_LAPLACE);
      single_pixel(PIX_MAX);

      // Random phases; a phase may keep the frame size and resume a cut frame.
      while (random_items < ITEM_TARGET) begin
         wait_idle();
         csr_write(CSR_KERNEL_MODE, $urandom_range(0, 3));
         if ($urandom_range(0, 3) != 0) begin
            csr_write(CSR_IMAGE_WIDTH, pick_width());
            csr_write(CSR_IMAGE_HEIGHT, pick_height());
         end
         @(negedge clock);
         play_frames($urandom_range(1, 3), 1'b1);
      end

      // Oversized dimensions clamp to the full row and full column.
      wait_idle();
      csr_write(CSR_KERNEL_MODE, $urandom_range(0, 3));
      csr_write(CSR_IMAGE_WIDTH, 11'h7FF);
      csr_write(CSR_IMAGE_HEIGHT, 1);
      @(negedge clock);
      play_frames(1, 1'b0);
      wait_idle();
      csr_write(CSR_KERNEL_MODE, $urandom_range(0, 3));
      csr_write(CSR_IMAGE_WIDTH, 1);
      csr_write(CSR_IMAGE_HEIGHT, 11'h7FF);
      @(negedge clock);
      play_frames(1, 1'b0);
      wait_idle();

      $display("Covered %0d pixels and %0d flush ticks (%0d early ticks ignored), %0d register writes.",
               n_pixels, n_ticks, ignored_ticks, csr_writes);
      $display("Checked %0d results across %0d finished frames with %0d mismatches.",
               n_results, n_frames, errors);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/icz_pkg.sv
rtl/icz_front.sv
rtl/icz_queue.sv
rtl/icz_back.sv
rtl/image_conv3x3_zero_pad.sv
verif/tb.sv
